/* rtl/tcw_pkg.sv */
// Shared definitions for the text console writer: field widths, codes,
// defaults and the command and status structs between controller and datapath.
// No dependencies.
package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Fixed widths of the item fields.
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned CELL_W  = CHAR_W + COLOR_W;

  // Item function codes. The fourth code is unused and changes nothing.
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'd32;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // input beat taken this cycle
    logic respond;      // load result register with the cursor, cell fields zero
    logic read_done;    // load result register with the cell read last cycle
    logic init_step;    // reset clearing pass: zero one cell
    logic clear_step;   // clear screen: blank one cell
    logic scroll_step;  // scroll copy: read one cell, write the previous one up
    logic fill_step;    // blank a bottom-row cell, or place the pending put
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;       // result register is empty or drains this cycle
    logic scroll_needed;  // a put now would wrap past the last row
    logic at_row_base;    // sweep counter sits at the first cell of the last row
    logic at_end;         // sweep counter sits at the last cell
  } tcw_status_t;

endpackage

/* rtl/tcw_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned WIDTH = tcw_pkg::CELL_W,
  parameter int unsigned DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcw_dpath.sv */
// Datapath of the text console writer: cursor, color register, sweep counter,
// screen RAM and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dpath #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::tcw_cmd_t            cmd_i,
  output tcw_pkg::tcw_status_t         status_o,
  input  logic [tcw_pkg::FUNC_W-1:0]   func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index_i,
  input  logic                         text_color_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  text_color_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0]  cell_color_o,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_o
);

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned LastBase  = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLUMNS + 1);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [tcw_pkg::COLOR_W-1:0] color_q;
  logic [tcw_pkg::CHAR_W-1:0]  char_q;
  logic pend_q, range_q;
  logic out_valid_q, out_valid_d;
  logic [tcw_pkg::CHAR_W-1:0]  out_char_q;
  logic [tcw_pkg::COLOR_W-1:0] out_color_q;
  logic [tcw_pkg::ROW_W-1:0]   out_row_q;
  logic [tcw_pkg::COL_W-1:0]   out_col_q;

  logic is_put, is_nl, line_full, last_row, in_range, at_row_base, at_end, addr_step;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata, blank;

  assign is_put      = (func_i == tcw_pkg::FUNC_PUT);
  assign is_nl       = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign line_full   = (col_q == CW'(COLUMNS));
  assign last_row    = (row_q == RW'(ROWS - 1));
  assign in_range    = (32'(cell_index_i) < 32'(CellCount));
  assign at_row_base = (addr_q == AW'(LastBase));
  assign at_end      = (addr_q == AW'(CellCount - 1));
  assign blank       = {color_q, tcw_pkg::SPACE_CODE};

  assign status_o.out_free      = !out_valid_q || !out_stall_i;
  assign status_o.scroll_needed = last_row && (is_nl || line_full);
  assign status_o.at_row_base   = at_row_base;
  assign status_o.at_end        = at_end;

  // Cursor moves as soon as a put is accepted; a scroll only touches the store.
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    base_d = base_q;
    if (cmd_i.accept && is_put) begin
      if (is_nl || line_full) begin
        col_d = is_nl ? CW'(0) : CW'(1);
        if (!last_row) begin
          row_d  = row_q + RW'(1);
          base_d = base_q + AW'(COLUMNS);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = blank;
    if (cmd_i.accept && is_put && !is_nl && !(line_full && last_row)) begin
      ram_we    = 1'b1;
      ram_waddr = line_full ? base_q + AW'(COLUMNS) : base_q + AW'(col_q);
      ram_wdata = {color_q, char_code_i};
    end else if (cmd_i.init_step) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd_i.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.scroll_step && (addr_q != '0)) begin
      // The cell read in the previous cycle lands one row higher.
      ram_we    = 1'b1;
      ram_waddr = addr_q - AW'(1);
      ram_wdata = ram_rdata;
    end else if (cmd_i.fill_step) begin
      ram_we = 1'b1;
      if (at_row_base && pend_q) begin
        ram_wdata = {color_q, char_q};
      end
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_q + AW'(COLUMNS);
    if (cmd_i.accept && (func_i == tcw_pkg::FUNC_READ) && in_range) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(cell_index_i);
    end else if (cmd_i.scroll_step && !at_row_base) begin
      ram_re = 1'b1;
    end
  end

  // The scroll holds the counter at the row base so the fill starts there.
  assign addr_step = cmd_i.init_step || cmd_i.clear_step || cmd_i.fill_step ||
                     (cmd_i.scroll_step && !at_row_base);

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.accept) begin
      addr_d = '0;
    end else if (addr_step) begin
      addr_d = addr_q + AW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.respond || cmd_i.read_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      addr_q      <= '0;
      color_q     <= tcw_pkg::TEXT_COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      if (text_color_we_i) begin
        color_q <= text_color_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q  <= char_code_i;
      pend_q  <= line_full && !is_nl;
      range_q <= in_range;
    end
    if (cmd_i.respond) begin
      out_char_q  <= '0;
      out_color_q <= '0;
      out_row_q   <= tcw_pkg::ROW_W'(row_d);
      out_col_q   <= tcw_pkg::COL_W'(col_d);
    end else if (cmd_i.read_done) begin
      out_char_q  <= range_q ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
      out_color_q <= range_q ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
      out_row_q   <= tcw_pkg::ROW_W'(row_q);
      out_col_q   <= tcw_pkg::COL_W'(col_q);
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CellCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = out_char_q;
  assign cell_color_o = out_color_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

endmodule

/* rtl/tcw_ctrl.sv */
// Controller of the text console writer: sequences accepts, reads and the
// clearing, scroll and fill sweeps. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tcw_pkg::FUNC_W-1:0]  func_i,
  input  tcw_pkg::tcw_status_t        status_i,
  output tcw_pkg::tcw_cmd_t           cmd_o
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_CLEAR  = 6'b001000,
    ST_SCROLL = 6'b010000,
    ST_FILL   = 6'b100000
  } tcw_state_e;

  tcw_state_e state_q, state_d;
  logic       in_ready;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_ready = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.at_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = status_i.out_free;
        if (in_valid_i && in_ready) begin
          cmd_o.accept = 1'b1;
          unique case (func_i)
            tcw_pkg::FUNC_PUT: begin
              if (status_i.scroll_needed) begin
                state_d = ST_SCROLL;
              end else begin
                cmd_o.respond = 1'b1;
              end
            end
            tcw_pkg::FUNC_READ:  state_d = ST_READ;
            tcw_pkg::FUNC_CLEAR: state_d = ST_CLEAR;
            default:             cmd_o.respond = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.read_done = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.at_end) begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (status_i.at_row_base) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.at_end) begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !in_ready;

endmodule

/* rtl/text_console_writer.sv */
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dpath (and tcw_ram below it).
//
// Text console over a ROWS x COLUMNS screen of 16-bit cells, character in the
// low byte and attribute in the high byte. Each input beat carries one item:
// put writes a character at the cursor in the current text color (a newline,
// or a put on a full line, moves to the next row and scrolls the screen up
// on the last row, blanking the new bottom row), read returns one cell, and
// clear blanks every cell without moving the cursor. Every item gives exactly
// one result beat that reports the cursor after the item. The screen lives in
// one RAM with one write and one registered read port. A put that does not
// scroll and the unused function code load the result register in the cycle
// they are taken, so puts stream at one beat per cycle while the output is
// not stalled; a read loads its cell into the result register from the READ
// state; a clear blanks the cells one by one; a put that scrolls takes the
// beat, copies rows up, then fills the bottom row. After reset a clearing
// pass zeroes the screen, one cell per cycle, and input stays stalled until
// it ends. A finished result sits in an output register, so a new item is
// taken in the same cycle the previous result leaves. The text color register
// may be written at any idle time and applies to later items.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::FUNC_W-1:0]   func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index_i,
  input  logic                         text_color_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  text_color_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0]  cell_color_o,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_o
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  // The controller owns the handshake on the input side and the sweep order.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the cursor, the screen store and the result register.
  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .cell_index_i    (cell_index_i),
    .text_color_we_i (text_color_we_i),
    .text_color_i    (text_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cell_char_o     (cell_char_o),
    .cell_color_o    (cell_color_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o)
  );

endmodule

/* test/text_console_writer_chk.sv */
// Scoreboard for the text console writer: watches both channels and the
// text color port, predicts every result beat and compares it field by field.
// Depends on tcw_pkg.
module text_console_writer_chk
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [INDEX_W-1:0]  cell_index_i,
  input  logic                text_color_we_i,
  input  logic [COLOR_W-1:0]  text_color_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CHAR_W-1:0]   cell_char_i,
  input  logic [COLOR_W-1:0]  cell_color_i,
  input  logic [ROW_W-1:0]    cursor_row_i,
  input  logic [COL_W-1:0]    cursor_col_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } cursor_report_t;

  // Shadow copy of the screen, cursor and pen color.
  logic [CELL_W-1:0]  screen [CELLS];
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic [COLOR_W-1:0] pen_color;

  cursor_report_t     due_reports [$];
  cursor_report_t     want;
  int unsigned        fails = 0;
  int                 k;

  // Moves the cursor to the start of the next row, scrolling on the last one.
  function automatic void start_next_line();
    int i;
    cursor_col = '0;
    if (cursor_row < ROWS - 1) begin
      cursor_row = cursor_row + 1'b1;
    end else begin
      for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (i = 0; i < COLUMNS; i++) screen[(ROWS - 1) * COLUMNS + i] = {pen_color, SPACE_CODE};
    end
  endfunction

  function automatic cursor_report_t apply_console_item(logic [FUNC_W-1:0]  f,
                                                        logic [CHAR_W-1:0]  ch,
                                                        logic [INDEX_W-1:0] idx);
    cursor_report_t rep;
    int i;
    rep = '0;
    case (f)
      FUNC_PUT: begin
        if (ch == NEWLINE_CODE) begin
          start_next_line();
        end else begin
          if (cursor_col >= COLUMNS) start_next_line();
          screen[int'(cursor_row) * COLUMNS + int'(cursor_col)] = {pen_color, ch};
          cursor_col = cursor_col + 1'b1;
        end
      end
      FUNC_READ: begin
        if (idx < CELLS) begin
          rep.ch    = screen[idx][CHAR_W-1:0];
          rep.color = screen[idx][CELL_W-1:CHAR_W];
        end
      end
      FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {pen_color, SPACE_CODE};
      end
      default: ;
    endcase
    rep.row = cursor_row;
    rep.col = cursor_col;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < CELLS; k++) screen[k] = '0;
      cursor_row = '0;
      cursor_col = '0;
      pen_color  = TEXT_COLOR_RESET;
      due_reports.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          $error("result beat arrived with no item outstanding");
          fails++;
        end else begin
          want = due_reports.pop_front();
          check_field("cell_char", want.ch, cell_char_i);
          check_field("cell_color", want.color, cell_color_i);
          check_field("cursor_row", want.row, cursor_row_i);
          check_field("cursor_col", want.col, cursor_col_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_reports.push_back(apply_console_item(func_i, char_code_i, cell_index_i));
      end
      // A color write only affects items taken after it.
      if (text_color_we_i) pen_color = text_color_i;
    end
    fail_count_o <= fails;
    pending_o    <= due_reports.size();
  end

endmodule

/* test/text_console_writer_tb.sv */
// Top of the text console writer testbench: clock, reset, item stimulus,
// random output back-pressure, watchdog and verdict.
// Depends on tcw_pkg, text_console_writer and text_console_writer_chk.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS_DEF * ROWS_DEF;

  // The fourth function code is not used by the block; it must change nothing.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // A scroll or a clear takes one pass over the screen, and so does the
  // clearing pass after reset. The limit covers such a pass plus the longest
  // output stall with room to spare.
  localparam int unsigned STALL_LIMIT = 20000;

  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 175;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func          = FUNC_PUT;
  logic [CHAR_W-1:0]    char_code     = '0;
  logic [INDEX_W-1:0]   cell_index    = '0;
  logic                 text_color_we = 1'b0;
  logic [COLOR_W-1:0]   text_color    = TEXT_COLOR_RESET;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [CHAR_W-1:0]    cell_char;
  logic [COLOR_W-1:0]   cell_color;
  logic [ROW_W-1:0]     cursor_row;
  logic [COL_W-1:0]     cursor_col;

  int unsigned          fail_count;
  int unsigned          pending;

  // Stimulus bookkeeping, used for the closing summary.
  int unsigned          items_sent = 0;
  int unsigned          sent_by_func [4] = '{0, 0, 0, 0};
  int unsigned          color_writes = 0;
  bit                   gaps_on = 1'b1;

  int unsigned          idle_cycles = 0;
  int unsigned          stall_hold  = 0;
  int unsigned          stall_pick;

  always #5 clk = ~clk;

  text_console_writer DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .char_code_i     (char_code),
    .cell_index_i    (cell_index),
    .text_color_we_i (text_color_we),
    .text_color_i    (text_color),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .cell_char_o     (cell_char),
    .cell_color_o    (cell_color),
    .cursor_row_o    (cursor_row),
    .cursor_col_o    (cursor_col)
  );

  text_console_writer_chk u_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .func_i          (func),
    .char_code_i     (char_code),
    .cell_index_i    (cell_index),
    .text_color_we_i (text_color_we),
    .text_color_i    (text_color),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .cell_char_i     (cell_char),
    .cell_color_i    (cell_color),
    .cursor_row_i    (cursor_row),
    .cursor_col_i    (cursor_col),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Output back-pressure. Each choice holds for a random number of cycles:
  // half the time a free-running stretch, otherwise a short stall and now and
  // then a long one. The stall is independent of the block's state, so it
  // lands on plain puts, reads, scrolls and clears alike.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 30);
      end else if (stall_pick < 90) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 60);
      end
    end
  end

  // Watchdog: the run is stuck if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("text_console_writer_tb failed");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes the beat, then
  // optionally leaves the input idle for a while. Called right after a rising
  // edge, so every assignment lands on a clock edge.
  task automatic send_item(input logic [FUNC_W-1:0]  f,
                           input logic [CHAR_W-1:0]  ch,
                           input logic [INDEX_W-1:0] idx);
    int unsigned roll;
    int unsigned gap;
    in_valid   <= 1'b1;
    func       <= f;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    items_sent++;
    sent_by_func[f]++;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) begin
        gap = $urandom_range(10, 40);
      end else if (roll >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result has come back. The
  // scoreboard count is registered, so it lags the last beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_text_color(input logic [COLOR_W-1:0] hue);
    text_color_we <= 1'b1;
    text_color    <= hue;
    @(posedge clk);
    text_color_we <= 1'b0;
    color_writes++;
  endtask

  // Mostly cells on the screen, sometimes indexes past its end.
  function automatic logic [INDEX_W-1:0] pick_read_index();
    if ($urandom_range(0, 99) < 85) return INDEX_W'($urandom_range(0, CELLS - 1));
    return INDEX_W'($urandom_range(CELLS, (1 << INDEX_W) - 1));
  endfunction

  initial begin
    int unsigned       phase;
    int unsigned       budget;
    int unsigned       pick;
    int unsigned       line_len;
    logic [COLOR_W-1:0] hue;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first under the reset color. The block is still running
    // its clearing pass here, so the first beat waits on the stall.
    send_item(FUNC_READ, 8'h00, 11'd0);             // cleared cell at the start
    send_item(FUNC_READ, 8'hFF, INDEX_W'(CELLS - 1)); // last cell on the screen
    send_item(FUNC_READ, 8'h00, INDEX_W'(CELLS));     // first index past the end
    send_item(FUNC_READ, 8'h00, 11'h7FF);           // largest index
    send_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
    send_item(FUNC_PUT, 8'h00, 11'h7FF);
    send_item(FUNC_PUT, 8'hFF, 11'd0);
    send_item(FUNC_PUT, 8'h41, 11'd5);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd1);
    send_item(FUNC_READ, 8'h00, 11'd2);
    send_item(FUNC_PUT, NEWLINE_CODE, 11'd0);
    send_item(FUNC_PUT, NEWLINE_CODE, 11'd0);       // an empty line
    send_item(FUNC_READ, 8'h00, INDEX_W'(COLUMNS_DEF));
    send_item(FUNC_CLEAR, 8'h00, 11'd0);            // the cursor must stay put
    send_item(FUNC_READ, 8'h00, 11'd0);
    drain_results();

    // Same checks under a new color: the put lands where the clear left the
    // cursor, and blanks take the color that is current at the clear.
    write_text_color(8'hF0);
    send_item(FUNC_PUT, 8'h5A, 11'd0);
    send_item(FUNC_READ, 8'h00, INDEX_W'(2 * COLUMNS_DEF));
    send_item(FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_item(FUNC_READ, 8'h00, INDEX_W'(CELLS - 1));
    send_item(FUNC_READ, 8'h00, INDEX_W'(2 * COLUMNS_DEF));

    // Random phases, each under its own color; the first two take the extremes.
    // Most bursts are lines of text of random length ending mostly in a newline,
    // so the cursor walks down to the last row and keeps scrolling. Some lines
    // run to or past a full row to hit the wrap. Reads, clears, the unused code
    // and fully random items are mixed in.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: hue = 8'h00;
        1: hue = 8'hFF;
        default: hue = COLOR_W'($urandom_range(0, 255));
      endcase
      write_text_color(hue);
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) begin
        // Roughly a third of the bursts run with no input gaps at all.
        gaps_on = ($urandom_range(0, 9) < 7);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          pick = $urandom_range(0, 99);
          if (pick < 80) begin
            line_len = $urandom_range(0, 25);
          end else if (pick < 92) begin
            line_len = $urandom_range(COLUMNS_DEF - 4, COLUMNS_DEF + 4);
          end else begin
            line_len = $urandom_range(COLUMNS_DEF + 5, 2 * COLUMNS_DEF + 10);
          end
          repeat (line_len) begin
            if ($urandom_range(0, 7) == 0) begin
              send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), pick_read_index());
            end
            send_item(FUNC_PUT, CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
          end
          if ($urandom_range(0, 99) < 85) begin
            send_item(FUNC_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, 2047)));
          end
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 6)) begin
            send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), pick_read_index());
          end
        end else if (pick < 90) begin
          send_item(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
                    INDEX_W'($urandom_range(0, 2047)));
        end else if (pick < 95) begin
          send_item(FUNC_UNUSED, CHAR_W'($urandom_range(0, 255)),
                    INDEX_W'($urandom_range(0, 2047)));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_item(FUNC_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
          end
        end
      end
    end

    drain_results();

    $display("Sent %0d items: %0d puts, %0d reads, %0d clears, %0d with the unused code.",
             items_sent, sent_by_func[FUNC_PUT], sent_by_func[FUNC_READ],
             sent_by_func[FUNC_CLEAR], sent_by_func[FUNC_UNUSED]);
    $display("Text color was rewritten %0d times, including both extremes.", color_writes);
    if (fail_count == 0) begin
      $display("text_console_writer_tb passed");
    end else begin
      $display("text_console_writer_tb failed");
    end
    $finish;
  end

endmodule

/* text_console_writer.f */
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_dpath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
test/text_console_writer_chk.sv
test/text_console_writer_tb.sv
